// ===== design/tpaoa_pkg.sv =====
package tpaoa_pkg;

    // Field and state widths
    localparam int ADC_W   = 12;
    localparam int TALLY_W = 32;
    localparam int SUM_W   = ADC_W + TALLY_W;
    localparam int TGT_W   = 16;
    localparam int STAT_W  = 2;
    localparam int BIT_W   = $clog2(ADC_W);
    localparam int NPH     = 3;
    localparam int PH_W    = 2;

    localparam logic [TGT_W-1:0]   TGT_RESET = TGT_W'(1024);
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [BIT_W-1:0]   BIT_TOP   = BIT_W'(ADC_W - 1);
    localparam logic [PH_W-1:0]    PH_LAST   = PH_W'(NPH - 1);

    // Operation codes
    localparam logic OP_ACCUM   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_RUNNING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    accumulate;
        logic    div_start;
        logic    div_step;
        logic    load_status;
        status_t status;
        logic    load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_restart;
        logic target_zero;
        logic below_target;
        logic div_done;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== design/tpaoa_ctrl.sv =====
module tpaoa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tpaoa_pkg::dp_stat_t   stat,
    output tpaoa_pkg::ctrl_cmd_t  cmd
);
    import tpaoa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_RUNNING;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stat.op_restart) begin
                    cmd.clear       = 1'b1;
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_RUNNING;
                    state_next      = S_EMIT;
                end else if (stat.target_zero) begin
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_INVALID;
                    state_next      = S_EMIT;
                end else begin
                    cmd.accumulate = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.below_target) begin
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_RUNNING;
                    state_next      = S_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    cmd.load_status = 1'b1;
                    cmd.status      = ST_COMPLETE;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tpaoa_dp.sv =====
module tpaoa_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpaoa_pkg::TGT_W-1:0]   cfg_data,
    input  logic                          s_operation,
    input  logic [tpaoa_pkg::ADC_W-1:0]   s_phase_a_sample,
    input  logic [tpaoa_pkg::ADC_W-1:0]   s_phase_b_sample,
    input  logic [tpaoa_pkg::ADC_W-1:0]   s_phase_c_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tpaoa_pkg::STAT_W-1:0]  m_status,
    output logic                          m_result_ready,
    output logic [tpaoa_pkg::ADC_W-1:0]   m_offset_a,
    output logic [tpaoa_pkg::ADC_W-1:0]   m_offset_b,
    output logic [tpaoa_pkg::ADC_W-1:0]   m_offset_c,
    input  tpaoa_pkg::ctrl_cmd_t          cmd,
    output tpaoa_pkg::dp_stat_t           stat
);
    import tpaoa_pkg::*;

    logic [TGT_W-1:0]   target_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [SUM_W-1:0]   sum_reg [NPH];
    logic [ADC_W-1:0]   avg_reg [NPH];
    logic               ready_reg;
    status_t            status_reg;

    // captured transaction
    logic               op_reg;
    logic [ADC_W-1:0]   sample_reg [NPH];

    // divider
    logic [SUM_W-1:0]   rem_reg;
    logic [ADC_W-1:0]   quo_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [PH_W-1:0]    ph_reg;
    logic [SUM_W-1:0]   divisor_sh;
    logic               div_ge;
    logic [SUM_W-1:0]   rem_next;
    logic [ADC_W-1:0]   quo_next;
    logic [PH_W-1:0]    ph_next;
    logic               last_bit;

    // output register
    logic               m_valid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic               m_ready_flag_reg;
    logic [ADC_W-1:0]   m_offset_reg [NPH];

    assign cfg_ready = 1'b1;

    // One restoring step: quotient bit bit_reg of sum / tally
    always_comb begin
        divisor_sh = {{(SUM_W - TALLY_W){1'b0}}, tally_reg} << bit_reg;
        div_ge     = (rem_reg >= divisor_sh);
        rem_next   = div_ge ? (rem_reg - divisor_sh) : rem_reg;
        quo_next   = div_ge ? (quo_reg | (ADC_W'(1) << bit_reg)) : quo_reg;
        ph_next    = ph_reg + PH_W'(1);
        last_bit   = (bit_reg == '0);
    end

    // Status toward the controller
    always_comb begin
        stat.op_restart   = (op_reg == OP_RESTART);
        stat.target_zero  = (target_reg == '0);
        stat.below_target = (tally_reg < {{(TALLY_W - TGT_W){1'b0}}, target_reg});
        stat.div_done     = last_bit && (ph_reg == PH_LAST);
        stat.out_busy     = m_valid_reg && !m_ready;
    end

    // Captured transaction fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= s_operation;
            sample_reg[0] <= s_phase_a_sample;
            sample_reg[1] <= s_phase_b_sample;
            sample_reg[2] <= s_phase_c_sample;
        end
    end

    // Divider working registers
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            ph_reg  <= '0;
            bit_reg <= BIT_TOP;
            rem_reg <= sum_reg[0];
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            if (last_bit) begin
                ph_reg  <= ph_next;
                bit_reg <= BIT_TOP;
                rem_reg <= (ph_reg == PH_LAST) ? rem_next : sum_reg[ph_next];
                quo_reg <= '0;
            end else begin
                bit_reg <= bit_reg - BIT_W'(1);
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
        end
    end

    // Calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TGT_RESET;
            tally_reg  <= '0;
            ready_reg  <= 1'b0;
            status_reg <= ST_RUNNING;
            for (int i = 0; i < NPH; i++) begin
                sum_reg[i] <= '0;
                avg_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
            if (cmd.load_status) begin
                status_reg <= cmd.status;
            end
            if (cmd.clear) begin
                tally_reg <= '0;
                ready_reg <= 1'b0;
                for (int i = 0; i < NPH; i++) begin
                    sum_reg[i] <= '0;
                    avg_reg[i] <= '0;
                end
            end else if (cmd.accumulate && (tally_reg != TALLY_MAX)) begin
                tally_reg <= tally_reg + TALLY_W'(1);
                for (int i = 0; i < NPH; i++) begin
                    sum_reg[i] <= sum_reg[i] + {{(SUM_W - ADC_W){1'b0}}, sample_reg[i]};
                end
            end else if (cmd.div_step && last_bit) begin
                avg_reg[ph_reg] <= quo_next;
                if (ph_reg == PH_LAST) begin
                    ready_reg <= 1'b1;
                end
            end
        end
    end

    // Output register: offsets read as zero until ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg     <= status_reg;
            m_ready_flag_reg <= ready_reg;
            for (int i = 0; i < NPH; i++) begin
                m_offset_reg[i] <= ready_reg ? avg_reg[i] : '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_ready = m_ready_flag_reg;
    assign m_offset_a     = m_offset_reg[0];
    assign m_offset_b     = m_offset_reg[1];
    assign m_offset_c     = m_offset_reg[2];

endmodule

// ===== design/three_phase_adc_offset_averager_core.sv =====
// Each transaction is captured in IDLE and judged in EVAL: a restart or an invalid target
// goes on to EMIT, a tally still below target passes CHECK, and a full tally passes CHECK
// and DIV. One transaction at a time: the shared bit-serial divider works the three phases
// in turn, and the next sample is taken only after the result has been loaded in EMIT.
// Synchronous active-low reset: sums, tally, offsets and ready flag cleared, target 1024.
module three_phase_adc_offset_averager_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpaoa_pkg::TGT_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [tpaoa_pkg::ADC_W-1:0]   s_phase_a_sample,
    input  logic [tpaoa_pkg::ADC_W-1:0]   s_phase_b_sample,
    input  logic [tpaoa_pkg::ADC_W-1:0]   s_phase_c_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tpaoa_pkg::STAT_W-1:0]  m_status,
    output logic                          m_result_ready,
    output logic [tpaoa_pkg::ADC_W-1:0]   m_offset_a,
    output logic [tpaoa_pkg::ADC_W-1:0]   m_offset_b,
    output logic [tpaoa_pkg::ADC_W-1:0]   m_offset_c
);
    import tpaoa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer
    tpaoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Accumulators, divider and output register
    tpaoa_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_operation      (s_operation),
        .s_phase_a_sample (s_phase_a_sample),
        .s_phase_b_sample (s_phase_b_sample),
        .s_phase_c_sample (s_phase_c_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_ready   (m_result_ready),
        .m_offset_a       (m_offset_a),
        .m_offset_b       (m_offset_b),
        .m_offset_c       (m_offset_c),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpaoa_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 50;
    localparam int RANDOM_PER_MODE = 460;
    localparam int MAX_PRINTED = 100;
    localparam logic [ADC_W-1:0] ADC_MAX = '1;
    localparam logic [TGT_W-1:0] TGT_MAX = '1;

    // One sample transaction as offered on the input channel
    typedef struct packed {
        logic             operation;
        logic [ADC_W-1:0] phase_a;
        logic [ADC_W-1:0] phase_b;
        logic [ADC_W-1:0] phase_c;
    } adc_triple_t;

    // One result transaction
    typedef struct packed {
        status_t          status;
        logic             result_ready;
        logic [ADC_W-1:0] offset_a;
        logic [ADC_W-1:0] offset_b;
        logic [ADC_W-1:0] offset_c;
    } offset_report_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TGT_W-1:0]   cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = OP_ACCUM;
    logic [ADC_W-1:0]   s_phase_a_sample = '0;
    logic [ADC_W-1:0]   s_phase_b_sample = '0;
    logic [ADC_W-1:0]   s_phase_c_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic               m_result_ready;
    logic [ADC_W-1:0]   m_offset_a;
    logic [ADC_W-1:0]   m_offset_b;
    logic [ADC_W-1:0]   m_offset_c;

    // Mirror of the calibration state
    logic [TGT_W-1:0]   cal_target = TGT_RESET;
    logic [TALLY_W-1:0] cal_tally = '0;
    logic [SUM_W-1:0]   cal_sum_a = '0;
    logic [SUM_W-1:0]   cal_sum_b = '0;
    logic [SUM_W-1:0]   cal_sum_c = '0;
    logic [ADC_W-1:0]   cal_avg_a = '0;
    logic [ADC_W-1:0]   cal_avg_b = '0;
    logic [ADC_W-1:0]   cal_avg_c = '0;
    logic               cal_ready = 1'b0;

    adc_triple_t    pending_triples[$];
    offset_report_t expected_offsets[$];
    adc_triple_t    offered_triple;
    int             open_items = 0;
    int             queued_total = 0;
    int             error_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    bit             send_pause = 1'b0;
    int             recv_hold_cycles = 0;
    int             cycle_count = 0;

    three_phase_adc_offset_averager_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_phase_a_sample (s_phase_a_sample),
        .s_phase_b_sample (s_phase_b_sample),
        .s_phase_c_sample (s_phase_c_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_ready   (m_result_ready),
        .m_offset_a       (m_offset_a),
        .m_offset_b       (m_offset_b),
        .m_offset_c       (m_offset_c)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Advance the calibration mirror by one transaction, return the expected result
    function automatic offset_report_t calibrate_step(input adc_triple_t triple);
        offset_report_t res;
        status_t        st;
        if (triple.operation == OP_RESTART) begin
            cal_tally = '0;
            cal_sum_a = '0;
            cal_sum_b = '0;
            cal_sum_c = '0;
            cal_avg_a = '0;
            cal_avg_b = '0;
            cal_avg_c = '0;
            cal_ready = 1'b0;
            st = ST_RUNNING;
        end else if (cal_target == '0) begin
            st = ST_INVALID;
        end else begin
            // tally saturates, sums stop growing with it
            if (cal_tally != TALLY_MAX) begin
                cal_sum_a = cal_sum_a + SUM_W'(triple.phase_a);
                cal_sum_b = cal_sum_b + SUM_W'(triple.phase_b);
                cal_sum_c = cal_sum_c + SUM_W'(triple.phase_c);
                cal_tally = cal_tally + TALLY_W'(1);
            end
            if (cal_tally < TALLY_W'(cal_target)) begin
                st = ST_RUNNING;
            end else begin
                cal_avg_a = ADC_W'(cal_sum_a / SUM_W'(cal_tally));
                cal_avg_b = ADC_W'(cal_sum_b / SUM_W'(cal_tally));
                cal_avg_c = ADC_W'(cal_sum_c / SUM_W'(cal_tally));
                cal_ready = 1'b1;
                st = ST_COMPLETE;
            end
        end
        res.status       = st;
        res.result_ready = cal_ready;
        res.offset_a     = cal_ready ? cal_avg_a : '0;
        res.offset_b     = cal_ready ? cal_avg_b : '0;
        res.offset_c     = cal_ready ? cal_avg_c : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_triple(input logic op, input logic [ADC_W-1:0] a,
                                input logic [ADC_W-1:0] b, input logic [ADC_W-1:0] c);
        adc_triple_t triple;
        triple = {op, a, b, c};
        pending_triples.push_back(triple);
        open_items++;
        queued_total++;
    endtask

    task automatic wait_for_drain();
        while (open_items != 0) @(posedge aclk);
    endtask

    // Register write, only with no transaction in flight
    task automatic write_target(input logic [TGT_W-1:0] value);
        wait_for_drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cal_target = value;
    endtask

    // Mostly a reading near a fixed offset, sometimes anywhere in range
    function automatic logic [ADC_W-1:0] pick_sample(input int center);
        int v;
        if ($urandom_range(0, 9) < 3)
            return ADC_W'($urandom_range(0, int'(ADC_MAX)));
        v = center + int'($urandom_range(0, 64)) - 32;
        if (v < 0)
            v = 0;
        if (v > int'(ADC_MAX))
            v = int'(ADC_MAX);
        return ADC_W'(v);
    endfunction

    // A calibration run: usually a restart, then enough samples to reach a target of 1 to 64
    task automatic queue_burst(input logic [TGT_W-1:0] target);
        int n;
        int ca;
        int cb;
        int cc;
        if (target == '0 || target > 16'd64)
            n = $urandom_range(2, 8);
        else
            n = int'(target) + $urandom_range(0, 5);
        ca = $urandom_range(0, int'(ADC_MAX));
        cb = $urandom_range(0, int'(ADC_MAX));
        cc = $urandom_range(0, int'(ADC_MAX));
        if ($urandom_range(0, 4) != 0)
            queue_triple(OP_RESTART, ADC_W'($urandom), ADC_W'($urandom), ADC_W'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                queue_triple(1'($urandom), ADC_W'($urandom), ADC_W'($urandom),
                             ADC_W'($urandom));
            else
                queue_triple(OP_ACCUM, pick_sample(ca), pick_sample(cb), pick_sample(cc));
        end
    endtask

    // Input channel driver
    always @(posedge aclk) begin : triple_driver
        logic offering;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                expected_offsets.push_back(calibrate_step(offered_triple));
                offering = 1'b0;
            end
            if (!offering && !send_pause && pending_triples.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                offered_triple = pending_triples.pop_front();
                s_operation      <= offered_triple.operation;
                s_phase_a_sample <= offered_triple.phase_a;
                s_phase_b_sample <= offered_triple.phase_b;
                s_phase_c_sample <= offered_triple.phase_c;
                offering = 1'b1;
            end
            s_valid <= offering;
        end
    end

    // Result channel monitor and ready generation
    always @(posedge aclk) begin : offset_monitor
        offset_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_offsets.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, status %0d",
                                              m_status));
                end else begin
                    want = expected_offsets.pop_front();
                    open_items--;
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_status, want.status));
                    if (m_result_ready !== want.result_ready)
                        report_mismatch($sformatf("result_ready got %0d want %0d",
                                                  m_result_ready, want.result_ready));
                    if (m_offset_a !== want.offset_a)
                        report_mismatch($sformatf("offset_a got %0d want %0d",
                                                  m_offset_a, want.offset_a));
                    if (m_offset_b !== want.offset_b)
                        report_mismatch($sformatf("offset_b got %0d want %0d",
                                                  m_offset_b, want.offset_b));
                    if (m_offset_c !== want.offset_c)
                        report_mismatch($sformatf("offset_c got %0d want %0d",
                                                  m_offset_c, want.offset_c));
                end
            end
            // long hold-off first, then random stalls
            if (recv_hold_cycles != 0) begin
                recv_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TGT_W-1:0] target;
        int               mode_end;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 19;
        recv_idle_pct = 49;

        // Reset target: still running after a few samples, restart clears
        queue_triple(OP_ACCUM, '0, '0, '0);
        queue_triple(OP_ACCUM, ADC_MAX, ADC_MAX, ADC_MAX);
        queue_triple(OP_RESTART, ADC_MAX, ADC_MAX, ADC_MAX);

        // Target of one: every sample completes
        write_target(16'd1);
        queue_triple(OP_ACCUM, ADC_MAX, ADC_MAX, ADC_MAX);
        queue_triple(OP_ACCUM, '0, '0, '0);
        queue_triple(OP_ACCUM, 12'hAAA, 12'h555, 12'h001);
        queue_triple(OP_RESTART, '0, '0, '0);
        queue_triple(OP_ACCUM, 12'h555, 12'hAAA, 12'hFFE);

        // Target reached exactly on the third sample
        write_target(16'd3);
        queue_triple(OP_RESTART, 12'h123, 12'h456, 12'h789);
        queue_triple(OP_ACCUM, 12'h800, 12'h7FF, 12'h123);
        queue_triple(OP_ACCUM, 12'h7FF, 12'h800, 12'hFED);
        queue_triple(OP_ACCUM, 12'h801, 12'h7FE, 12'h001);

        // Target raised past the tally after ready: running, old offsets kept
        write_target(16'd20);
        queue_triple(OP_ACCUM, 12'h010, 12'h020, 12'h030);

        // Zero target: samples are invalid and change nothing, a restart still clears
        write_target(16'd0);
        queue_triple(OP_ACCUM, ADC_MAX, '0, ADC_MAX);
        queue_triple(OP_RESTART, '0, ADC_MAX, '0);
        queue_triple(OP_ACCUM, 12'h001, 12'h002, 12'h003);

        // Largest target
        write_target(TGT_MAX);
        queue_triple(OP_ACCUM, ADC_MAX, ADC_MAX, ADC_MAX);
        queue_triple(OP_ACCUM, 12'h001, 12'h001, 12'h001);
        queue_triple(OP_RESTART, ADC_MAX, '0, ADC_MAX);

        // Small averages with truncation
        write_target(16'd2);
        queue_triple(OP_ACCUM, 12'd1, 12'd2, 12'd3);
        queue_triple(OP_ACCUM, 12'd2, 12'd3, 12'd4);
        queue_triple(OP_ACCUM, 12'hFFE, 12'd0, 12'd7);

        // Random calibration runs over three idling modes
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mode_end = queued_total + RANDOM_PER_MODE;
            while (queued_total < mode_end) begin
                case ($urandom_range(0, 9))
                    0: target = '0;
                    1: target = TGT_MAX;
                    2: target = TGT_W'($urandom_range(17, 40));
                    default: target = TGT_W'($urandom_range(1, 16));
                endcase
                write_target(target);
                if (mode == 0 && queued_total < mode_end - RANDOM_PER_MODE + 1)
                    recv_hold_cycles = 300;
                repeat ($urandom_range(1, 3)) queue_burst(target);
                if (mode == 1 && queued_total < mode_end - RANDOM_PER_MODE + 60) begin
                    // hold the sender until every outstanding result is back
                    while (expected_offsets.size() == 0) @(posedge aclk);
                    send_pause = 1'b1;
                    do @(posedge aclk); while (s_valid || expected_offsets.size() != 0);
                    send_pause = 1'b0;
                end
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== three_phase_adc_offset_averager_core.f =====
design/tpaoa_pkg.sv
design/tpaoa_ctrl.sv
design/tpaoa_dp.sv
design/three_phase_adc_offset_averager_core.sv
tb/testbench.sv
